>>> src/d2ptz_pkg.sv
// d2ptz_pkg: shared types, register indexes, direction codes and constants
// for the drag-to-pan/tilt direction commander
// no dependencies
package d2ptz_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_WIDTH   = 3'd0,
		REG_VIEW_HEIGHT  = 3'd1,
		REG_DEAD_ZONE    = 3'd2,
		REG_SPEED        = 3'd3,
		REG_VIDEO_ACTIVE = 3'd4
	} cfg_reg_t;

	// register widths and reset values
	localparam int VIEW_W   = 13;
	localparam int CENTRE_W = VIEW_W - 1;
	localparam int RADIUS_W = 12;
	localparam int SPEED_W  = 8;

	localparam logic [VIEW_W-1:0]   VIEW_WIDTH_RST  = 13'd640;
	localparam logic [VIEW_W-1:0]   VIEW_HEIGHT_RST = 13'd480;
	localparam logic [RADIUS_W-1:0] DEAD_ZONE_RST   = 12'd0;
	localparam logic [SPEED_W-1:0]  SPEED_RST       = 8'd32;

	// default pointer coordinate width
	localparam int COORD_BITS_DEF = 13;

	// tan(22.5 deg) in Q32; tan(67.5 deg) = 2 + tan(22.5 deg)
	localparam int TAN_W = 31;
	localparam logic [TAN_W-1:0] TAN22_Q32 = 31'd1779033704;

	// stop speed byte
	localparam logic [SPEED_W-1:0] STOP_SPEED = 8'h0C;

	// pointer event kinds
	typedef enum logic [1:0] {
		MODE_MOVE    = 2'd0,
		MODE_PRESS   = 2'd1,
		MODE_RELEASE = 2'd2,
		MODE_LEAVE   = 2'd3
	} mode_t;

	// sector codes, counterclockwise from right
	localparam int DIR_W = 4;
	localparam logic [DIR_W-1:0] DIR_NONE       = 4'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT      = 4'd1;
	localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 4'd2;
	localparam logic [DIR_W-1:0] DIR_UP         = 4'd3;
	localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 4'd4;
	localparam logic [DIR_W-1:0] DIR_LEFT       = 4'd5;
	localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 4'd6;
	localparam logic [DIR_W-1:0] DIR_DOWN       = 4'd7;
	localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 4'd8;

	// command bytes
	localparam logic [7:0] CMD_STOP       = 8'h00;
	localparam logic [7:0] CMD_RIGHT      = 8'h02;
	localparam logic [7:0] CMD_LEFT       = 8'h04;
	localparam logic [7:0] CMD_UP         = 8'h08;
	localparam logic [7:0] CMD_DOWN       = 8'h10;
	localparam logic [7:0] CMD_UP_RIGHT   = 8'h0A;
	localparam logic [7:0] CMD_UP_LEFT    = 8'h0C;
	localparam logic [7:0] CMD_DOWN_LEFT  = 8'h14;
	localparam logic [7:0] CMD_DOWN_RIGHT = 8'h12;

	// one result beat
	typedef struct packed {
		logic               cmd_valid;
		logic [7:0]         code;
		logic [SPEED_W-1:0] speed;
		logic [DIR_W-1:0]   hover;
		logic               last;
	} res_t;

	// result queue depth, room for the two beats of one event plus slack
	localparam int RES_DEPTH = 4;

	// sector to command byte
	function automatic logic [7:0] dir_code(input logic [DIR_W-1:0] dir);
		logic [7:0] code;
		unique case (dir)
			DIR_RIGHT:      code = CMD_RIGHT;
			DIR_UP_RIGHT:   code = CMD_UP_RIGHT;
			DIR_UP:         code = CMD_UP;
			DIR_UP_LEFT:    code = CMD_UP_LEFT;
			DIR_LEFT:       code = CMD_LEFT;
			DIR_DOWN_LEFT:  code = CMD_DOWN_LEFT;
			DIR_DOWN:       code = CMD_DOWN;
			DIR_DOWN_RIGHT: code = CMD_DOWN_RIGHT;
			default:        code = CMD_STOP;
		endcase
		return code;
	endfunction

endpackage

>>> src/drag_to_ptz_direction_commander_unit.sv
// A result beat passes stage registers s1, s2 and s3 and the result queue before it is offered.
// Throughput: one event per cycle while each event gives a single result beat and
// out_ready is not held low; an event that sends stop then start gives two result beats.
// A 4-entry result queue separates the result port from the 3-stage pipeline.
// Reset (arst_n low, asynchronous): registers to 640, 480, 0, 32, 0, all flags
// and directions cleared, pipeline and queue empty.
//
// top level of the drag-to-pan/tilt direction commander: sector classifier,
// command state and result queue; depends on d2ptz_pkg
module drag_to_ptz_direction_commander_unit #(
	parameter int COORD_BITS = d2ptz_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// event channel
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             mode,
	input  logic signed [COORD_BITS-1:0]           pos_x,
	input  logic signed [COORD_BITS-1:0]           pos_y,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   command_valid,
	output logic [7:0]                             command_code,
	output logic [7:0]                             pan_speed,
	output logic [7:0]                             tilt_speed,
	output logic [d2ptz_pkg::DIR_W-1:0]            hover_direction,
	output logic                                   last_result,
	// configuration channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [d2ptz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [d2ptz_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import d2ptz_pkg::*;

	// offset width: holds pointer minus centre and centre minus pointer
	localparam int DW  = ((COORD_BITS > CENTRE_W + 1) ? COORD_BITS : CENTRE_W + 1) + 1;
	localparam int AW  = DW - 1;
	localparam int SQW = 2 * AW;
	localparam int SUMW = SQW + 1;
	localparam int RSQW = 2 * RADIUS_W;
	localparam int PW  = TAN_W + AW;
	localparam int LW  = AW + 34;
	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	// configuration registers
	logic [VIEW_W-1:0]   view_width_q;
	logic [VIEW_W-1:0]   view_height_q;
	logic [RADIUS_W-1:0] dead_zone_q;
	logic [SPEED_W-1:0]  speed_q;
	logic                video_active_q;

	// command state
	logic             dragging_q;
	logic             captured_q;
	logic [DIR_W-1:0] commanded_q;
	logic [DIR_W-1:0] hovered_q;

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3, mv1, mv2, fire3, room;

	// stage 1: event beat
	mode_t                       mode_s1;
	logic signed [COORD_BITS-1:0] pos_x_s1;
	logic signed [COORD_BITS-1:0] pos_y_s1;

	// stage 2: products
	mode_t           mode_s2;
	logic [SQW-1:0]  sqx_s2, sqy_s2;
	logic [RSQW-1:0] rsq_s2;
	logic [PW-1:0]   p_s2;
	logic [AW-1:0]   ax_s2, ay_s2;
	logic            dxneg_s2, dypos_s2, dyz_s2;

	// stage 3: sector
	mode_t            mode_s3;
	logic [DIR_W-1:0] dir_s3;

	// result queue
	res_t             res_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	// ---------------------------------------------------------------
	// configuration port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q   <= VIEW_WIDTH_RST;
			view_height_q  <= VIEW_HEIGHT_RST;
			dead_zone_q    <= DEAD_ZONE_RST;
			speed_q        <= SPEED_RST;
			video_active_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIEW_WIDTH:   view_width_q   <= cfg_data[VIEW_W-1:0];
				REG_VIEW_HEIGHT:  view_height_q  <= cfg_data[VIEW_W-1:0];
				REG_DEAD_ZONE:    dead_zone_q    <= cfg_data[RADIUS_W-1:0];
				REG_SPEED:        speed_q        <= cfg_data[SPEED_W-1:0];
				REG_VIDEO_ACTIVE: video_active_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pipeline flow control; the last stage waits for room for two beats
	assign room  = cnt_q <= CNT_W'(RES_DEPTH - 2);
	assign fire3 = v_s3 && room;
	assign en3   = !v_s3 || fire3;
	assign mv2   = v_s2 && en3;
	assign en2   = !v_s2 || mv2;
	assign mv1   = v_s1 && en2;
	assign en1   = !v_s1 || mv1;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			mode_s1  <= mode_t'(mode);
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
		end
	end

	// ---------------------------------------------------------------
	// stage 1 logic: offsets from centre, magnitudes and products
	logic signed [DW-1:0] px_e, py_e, cx_e, cy_e, dx, dy, ndx, ndy;
	logic [AW-1:0]        ax, ay;

	always_comb begin
		px_e = DW'(pos_x_s1);
		py_e = DW'(pos_y_s1);
		cx_e = DW'(view_width_q[VIEW_W-1:1]);
		cy_e = DW'(view_height_q[VIEW_W-1:1]);
		dx   = px_e - cx_e;
		dy   = cy_e - py_e;
		ndx  = -dx;
		ndy  = -dy;
		ax   = dx[DW-1] ? ndx[AW-1:0] : dx[AW-1:0];
		ay   = dy[DW-1] ? ndy[AW-1:0] : dy[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			mode_s2  <= mode_s1;
			sqx_s2   <= SQW'(ax * ax);
			sqy_s2   <= SQW'(ay * ay);
			rsq_s2   <= RSQW'(dead_zone_q * dead_zone_q);
			p_s2     <= PW'(TAN22_Q32 * ax);
			ax_s2    <= ax;
			ay_s2    <= ay;
			dxneg_s2 <= dx[DW-1];
			dypos_s2 <= !dy[DW-1] && (dy != '0);
			dyz_s2   <= (dy == '0);
		end
	end

	// ---------------------------------------------------------------
	// stage 2 logic: dead zone and sector edge compares
	logic [SUMW-1:0]  dist2;
	logic [LW-1:0]    lhs, p_e, vbound;
	logic             dead, horiz, vert;
	logic [DIR_W-1:0] dir;

	always_comb begin
		dist2  = SUMW'(sqx_s2) + SUMW'(sqy_s2);
		dead   = dist2 < SUMW'(rsq_s2);
		lhs    = LW'({ay_s2, 32'd0});
		p_e    = LW'(p_s2);
		// tan 67.5 edge: ax * 2^33 + tan 22.5 product
		vbound = LW'({ax_s2, 33'd0}) + p_e;
		horiz  = dyz_s2 || (lhs < p_e);
		vert   = lhs >= vbound;
		priority if (dead) begin
			dir = DIR_NONE;
		end else if (horiz) begin
			dir = dxneg_s2 ? DIR_LEFT : DIR_RIGHT;
		end else if (vert) begin
			dir = dypos_s2 ? DIR_UP : DIR_DOWN;
		end else if (dypos_s2) begin
			dir = dxneg_s2 ? DIR_UP_LEFT : DIR_UP_RIGHT;
		end else begin
			dir = dxneg_s2 ? DIR_DOWN_LEFT : DIR_DOWN_RIGHT;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			mode_s3 <= mode_s2;
			dir_s3  <= dir;
		end
	end

	// ---------------------------------------------------------------
	// stage 3 logic: command state update and result beats
	logic             drag_d, cap_d;
	logic [DIR_W-1:0] cmd_d, hov_d;
	logic             want_stop, want_start;
	res_t             beat0, beat1;
	logic [1:0]       n_push;
	res_t             stop_beat, start_beat, idle_beat;

	always_comb begin
		drag_d     = dragging_q;
		cap_d      = captured_q;
		cmd_d      = commanded_q;
		hov_d      = hovered_q;
		want_stop  = 1'b0;
		want_start = 1'b0;

		unique case (mode_s3)
			MODE_MOVE: begin
				if (video_active_q) begin
					hov_d = dir_s3;
					if (dragging_q && captured_q && dir_s3 != commanded_q) begin
						want_stop  = commanded_q != DIR_NONE;
						want_start = dir_s3 != DIR_NONE;
						cmd_d      = dir_s3;
					end
				end
			end
			MODE_PRESS: begin
				if (video_active_q) begin
					drag_d     = 1'b1;
					cap_d      = 1'b1;
					hov_d      = dir_s3;
					cmd_d      = dir_s3;
					want_start = dir_s3 != DIR_NONE;
				end
			end
			MODE_RELEASE: begin
				cap_d     = 1'b0;
				want_stop = commanded_q != DIR_NONE;
				cmd_d     = DIR_NONE;
			end
			MODE_LEAVE: begin
				hov_d = DIR_NONE;
				if (dragging_q || commanded_q != DIR_NONE) begin
					want_stop = 1'b1;
					cmd_d     = DIR_NONE;
					drag_d    = 1'b0;
				end
			end
			default: ;
		endcase

		stop_beat  = '{cmd_valid: 1'b1, code: CMD_STOP, speed: STOP_SPEED,
		               hover: hov_d, last: !want_start};
		start_beat = '{cmd_valid: 1'b1, code: dir_code(dir_s3), speed: speed_q,
		               hover: hov_d, last: 1'b1};
		idle_beat  = '{cmd_valid: 1'b0, code: CMD_STOP, speed: '0,
		               hover: hov_d, last: 1'b1};

		// stop goes first when both are sent
		beat0  = want_stop ? stop_beat : (want_start ? start_beat : idle_beat);
		beat1  = start_beat;
		n_push = (want_stop && want_start) ? 2'd2 : 2'd1;
	end

	// state registers; video off also clears the hovered sector unless stage 3 fires in that cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dragging_q  <= 1'b0;
			captured_q  <= 1'b0;
			commanded_q <= DIR_NONE;
			hovered_q   <= DIR_NONE;
		end else if (fire3) begin
			dragging_q  <= drag_d;
			captured_q  <= cap_d;
			commanded_q <= cmd_d;
			hovered_q   <= hov_d;
		end else if (cfg_valid && cfg_reg_t'(cfg_index) == REG_VIDEO_ACTIVE
		             && video_active_q && !cfg_data[0]) begin
			hovered_q <= DIR_NONE;
		end
	end

	// ---------------------------------------------------------------
	// result queue
	logic pop;
	logic [PTR_W-1:0] wr_ptr_n1;
	res_t head;

	assign pop       = out_valid && out_ready;
	assign wr_ptr_n1 = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (fire3) begin
			res_q[wr_ptr_q] <= beat0;
			if (n_push == 2'd2) res_q[wr_ptr_n1] <= beat1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire3) wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop)   rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + (fire3 ? CNT_W'(n_push) : CNT_W'(0))
			               - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

	// head of queue drives the result port
	assign head            = res_q[rd_ptr_q];
	assign out_valid       = cnt_q != '0;
	assign command_valid   = head.cmd_valid;
	assign command_code    = head.code;
	assign pan_speed       = head.speed;
	assign tilt_speed      = head.speed;
	assign hover_direction = head.hover;
	assign last_result     = head.last;

endmodule

>>> sim/d2ptz_checker.sv
// d2ptz_checker: watches the event, result and register channels of the direction
// commander, predicts every result beat and compares it field by field
// depends on d2ptz_pkg
module d2ptz_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [1:0]                             mode,
	input  logic signed [d2ptz_pkg::COORD_BITS_DEF-1:0] pos_x,
	input  logic signed [d2ptz_pkg::COORD_BITS_DEF-1:0] pos_y,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   command_valid,
	input  logic [7:0]                             command_code,
	input  logic [7:0]                             pan_speed,
	input  logic [7:0]                             tilt_speed,
	input  logic [d2ptz_pkg::DIR_W-1:0]            hover_direction,
	input  logic                                   last_result,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [d2ptz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [d2ptz_pkg::CFG_DATA_W-1:0]       cfg_data,
	output int                                     mismatches,
	output int                                     pending,
	output int                                     events_seen,
	output int                                     beats_seen,
	output int                                     writes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import d2ptz_pkg::*;

	typedef struct packed {
		logic             cmd_valid;
		logic [7:0]       code;
		logic [7:0]       pan;
		logic [7:0]       tilt;
		logic [DIR_W-1:0] hover;
		logic             last;
	} ptz_beat_t;

	// sector edge slopes in Q32
	localparam longint TAN22 = longint'(TAN22_Q32);
	localparam longint TAN67 = (longint'(2) <<< 32) + TAN22;

	// command byte per sector, none first
	localparam logic [7:0] SECTOR_CMD [9] = '{
		CMD_STOP, CMD_RIGHT, CMD_UP_RIGHT, CMD_UP, CMD_UP_LEFT,
		CMD_LEFT, CMD_DOWN_LEFT, CMD_DOWN, CMD_DOWN_RIGHT
	};

	// register copies
	logic [VIEW_W-1:0]   view_w, view_h;
	logic [RADIUS_W-1:0] dead_r;
	logic [SPEED_W-1:0]  move_speed;
	logic                ctl_active;

	// command state copies
	logic             dragging_f, captured_f;
	logic [DIR_W-1:0] commanded_dir, hovered_dir;

	ptz_beat_t expected_beats [$];
	ptz_beat_t got_beat, want_beat;

	// sector of a pointer position around the view centre
	function automatic logic [DIR_W-1:0] sector_of(input longint px, input longint py);
		longint dx, dy, ax, ay, r, lhs;
		dx = px - longint'(view_w >> 1);
		dy = longint'(view_h >> 1) - py;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		r  = longint'(dead_r);
		if (dx * dx + dy * dy < r * r)
			return DIR_NONE;
		lhs = ay <<< 32;
		if (dy == 0 || lhs < TAN22 * ax)
			return (dx < 0) ? DIR_LEFT : DIR_RIGHT;
		if (lhs >= TAN67 * ax)
			return (dy > 0) ? DIR_UP : DIR_DOWN;
		if (dy > 0)
			return (dx < 0) ? DIR_UP_LEFT : DIR_UP_RIGHT;
		return (dx < 0) ? DIR_DOWN_LEFT : DIR_DOWN_RIGHT;
	endfunction

	function automatic ptz_beat_t cmd_beat(input logic [7:0] code, input logic [7:0] spd);
		ptz_beat_t b;
		b = '0;
		b.cmd_valid = 1'b1;
		b.code = code;
		b.pan  = spd;
		b.tilt = spd;
		return b;
	endfunction

	// advance the command state by one event and queue its result beats
	task automatic predict_event(input logic [1:0] ev_mode, input longint px, input longint py);
		ptz_beat_t beats [2];
		int n;
		logic [DIR_W-1:0] dir;
		n = 0;
		beats[0] = '0;
		beats[1] = '0;
		case (mode_t'(ev_mode))
			MODE_MOVE: begin
				if (ctl_active) begin
					dir = sector_of(px, py);
					hovered_dir = dir;
					if (dragging_f && captured_f && dir != commanded_dir) begin
						if (commanded_dir != DIR_NONE) begin
							beats[n] = cmd_beat(CMD_STOP, STOP_SPEED);
							n++;
						end
						if (dir != DIR_NONE) begin
							beats[n] = cmd_beat(SECTOR_CMD[dir], move_speed);
							n++;
						end
						commanded_dir = dir;
					end
				end
			end
			MODE_PRESS: begin
				if (ctl_active) begin
					captured_f = 1'b1;
					dragging_f = 1'b1;
					dir = sector_of(px, py);
					hovered_dir = dir;
					commanded_dir = DIR_NONE;
					if (dir != DIR_NONE) begin
						beats[n] = cmd_beat(SECTOR_CMD[dir], move_speed);
						n++;
						commanded_dir = dir;
					end
				end
			end
			MODE_RELEASE: begin
				captured_f = 1'b0;
				if (commanded_dir != DIR_NONE) begin
					beats[n] = cmd_beat(CMD_STOP, STOP_SPEED);
					n++;
					commanded_dir = DIR_NONE;
				end
			end
			default: begin
				hovered_dir = DIR_NONE;
				if (dragging_f || commanded_dir != DIR_NONE) begin
					beats[n] = cmd_beat(CMD_STOP, STOP_SPEED);
					n++;
					commanded_dir = DIR_NONE;
					dragging_f = 1'b0;
				end
			end
		endcase
		// an event with no command still gives one empty beat
		if (n == 0)
			n = 1;
		for (int k = 0; k < n; k++) begin
			beats[k].hover = hovered_dir;
			beats[k].last  = (k == n - 1);
			expected_beats.push_back(beats[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_w        = VIEW_WIDTH_RST;
			view_h        = VIEW_HEIGHT_RST;
			dead_r        = DEAD_ZONE_RST;
			move_speed    = SPEED_RST;
			ctl_active    = 1'b0;
			dragging_f    = 1'b0;
			captured_f    = 1'b0;
			commanded_dir = DIR_NONE;
			hovered_dir   = DIR_NONE;
			mismatches    = 0;
			pending       = 0;
			events_seen   = 0;
			beats_seen    = 0;
			writes_seen   = 0;
			expected_beats.delete();
		end else begin
			// result beat against the oldest expectation
			if (out_valid && out_ready) begin
				beats_seen = beats_seen + 1;
				got_beat.cmd_valid = command_valid;
				got_beat.code      = command_code;
				got_beat.pan       = pan_speed;
				got_beat.tilt      = tilt_speed;
				got_beat.hover     = hover_direction;
				got_beat.last      = last_result;
				if (expected_beats.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("%0t: result beat with none expected: valid=%0d code=%02h",
							$realtime, got_beat.cmd_valid, got_beat.code);
				end else begin
					want_beat = expected_beats.pop_front();
					if (got_beat !== want_beat) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display({"%0t: result mismatch, expected valid=%0d code=%02h ",
								"pan=%02h tilt=%02h hover=%0d last=%0d, got valid=%0d ",
								"code=%02h pan=%02h tilt=%02h hover=%0d last=%0d"},
								$realtime, want_beat.cmd_valid, want_beat.code,
								want_beat.pan, want_beat.tilt, want_beat.hover,
								want_beat.last, got_beat.cmd_valid, got_beat.code,
								got_beat.pan, got_beat.tilt, got_beat.hover,
								got_beat.last);
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				writes_seen = writes_seen + 1;
				case (cfg_reg_t'(cfg_index))
					REG_VIEW_WIDTH:  view_w = cfg_data[VIEW_W-1:0];
					REG_VIEW_HEIGHT: view_h = cfg_data[VIEW_W-1:0];
					REG_DEAD_ZONE:   dead_r = cfg_data[RADIUS_W-1:0];
					REG_SPEED:       move_speed = cfg_data[SPEED_W-1:0];
					REG_VIDEO_ACTIVE: begin
						if (ctl_active && !cfg_data[0])
							hovered_dir = DIR_NONE;
						ctl_active = cfg_data[0];
					end
					default: ;
				endcase
			end
			// event beat
			if (in_valid && in_ready) begin
				events_seen = events_seen + 1;
				predict_event(mode, longint'(pos_x), longint'(pos_y));
			end
			pending = expected_beats.size();
		end
	end

endmodule

>>> sim/drag_to_ptz_direction_commander_unit_tb.sv
// drag_to_ptz_direction_commander_unit_tb: clock, reset, pointer event and register
// stimulus with random idling on both channels; verdict from d2ptz_checker
// depends on d2ptz_pkg, d2ptz_checker and drag_to_ptz_direction_commander_unit
module drag_to_ptz_direction_commander_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import d2ptz_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] mode;
	logic signed [COORD_BITS_DEF-1:0] pos_x, pos_y;
	logic out_valid;
	logic out_ready = 1'b0;
	logic command_valid;
	logic [7:0] command_code, pan_speed, tilt_speed;
	logic [DIR_W-1:0] hover_direction;
	logic last_result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches, pending, events_seen, beats_seen, writes_seen;
	int cycle_cnt = 0;
	int counted = 0;
	int settings_run = 0;
	logic calm = 1'b0;

	// view as currently programmed, for aiming the pointer
	int cur_vw = 640, cur_vh = 480, cur_rad = 0;

	drag_to_ptz_direction_commander_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.command_valid(command_valid), .command_code(command_code),
		.pan_speed(pan_speed), .tilt_speed(tilt_speed),
		.hover_direction(hover_direction), .last_result(last_result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	d2ptz_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .pos_x(pos_x), .pos_y(pos_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.command_valid(command_valid), .command_code(command_code),
		.pan_speed(pan_speed), .tilt_speed(tilt_speed),
		.hover_direction(hover_direction), .last_result(last_result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending),
		.events_seen(events_seen), .beats_seen(beats_seen),
		.writes_seen(writes_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pending);
			$display("[drag_to_ptz_direction_commander_unit] ERROR");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);

	function automatic int clip_coord(input int v);
		if (v > 4095)
			return 4095;
		if (v < -4096)
			return -4096;
		return v;
	endfunction

	// pointer coordinate along one axis of the view
	function automatic int pick_coord(input int span, input int rad);
		int c, lim;
		c = span / 2;
		lim = rad + 24;
		case ($urandom_range(0, 9))
			0, 1: return int'($urandom_range(0, 8191)) - 4096;
			2: begin
				case ($urandom_range(0, 3))
					0: return -4096;
					1: return 4095;
					2: return 0;
					default: return c;
				endcase
			end
			3, 4, 5: return c + int'($urandom_range(0, 2 * lim)) - lim;
			default: return (span == 0) ? 0 : int'($urandom_range(0, span - 1));
		endcase
	endfunction

	// one event beat; entered and left at a falling edge, valid left high
	task automatic send_event(input mode_t m, input int x, input int y);
		while (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		pos_x    <= COORD_BITS_DEF'(clip_coord(x));
		pos_y    <= COORD_BITS_DEF'(clip_coord(y));
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		counted++;
	endtask

	task automatic send_random(input mode_t m);
		send_event(m, pick_coord(cur_vw, cur_rad), pick_coord(cur_vh, cur_rad));
	endtask

	// hold off until every expected beat has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// one register beat; valid is left high for the caller to drop
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_setting(input int vw, input int vh, input int rad, input int spd,
			input logic act);
		drain();
		write_reg(REG_VIEW_WIDTH, vw);
		write_reg(REG_VIEW_HEIGHT, vh);
		write_reg(REG_DEAD_ZONE, rad);
		write_reg(REG_SPEED, spd);
		write_reg(REG_VIDEO_ACTIVE, int'(act));
		// unused index, must be ignored
		write_reg(CFG_IDX_W'($urandom_range(5, 7)), int'($urandom_range(0, 8191)));
		cfg_valid <= 1'b0;
		cur_vw  = vw & 13'h1FFF;
		cur_vh  = vh & 13'h1FFF;
		cur_rad = rad & 12'hFFF;
		settings_run++;
	endtask

	// mostly press / drag / release gestures, the rest stray events
	task automatic run_phase(input int quota);
		int goal, moves;
		goal = counted + quota;
		while (counted < goal) begin
			if ($urandom_range(0, 99) < 75) begin
				send_random(MODE_PRESS);
				moves = $urandom_range(1, 8);
				repeat (moves)
					send_random(MODE_MOVE);
				if ($urandom_range(0, 99) < 85)
					send_random(MODE_RELEASE);
				else
					send_random(MODE_LEAVE);
				if ($urandom_range(0, 99) < 20)
					send_random(MODE_LEAVE);
			end else begin
				send_random(mode_t'($urandom_range(0, 3)));
			end
			if ($urandom_range(0, 99) < 3)
				drain();
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MODE_MOVE;
		pos_x     = '0;
		pos_y     = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_VIEW_WIDTH;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// control off after reset: only empty beats
		send_event(MODE_MOVE, 320, 240);
		send_event(MODE_PRESS, 400, 240);
		send_event(MODE_RELEASE, 0, 0);
		send_event(MODE_LEAVE, 0, 0);
		drain();
		write_reg(REG_VIDEO_ACTIVE, 1);
		cfg_valid <= 1'b0;

		// hover at exact centre, press there, then sweep all sectors while captured
		send_event(MODE_MOVE, 320, 240);
		send_event(MODE_PRESS, 320, 240);
		send_event(MODE_MOVE, 400, 100);
		send_event(MODE_MOVE, 320, 0);
		send_event(MODE_MOVE, 200, 100);
		send_event(MODE_MOVE, 0, 240);
		send_event(MODE_MOVE, 100, 400);
		send_event(MODE_MOVE, 320, 479);
		send_event(MODE_MOVE, 500, 400);
		send_event(MODE_MOVE, 4095, 240);
		send_event(MODE_MOVE, -4096, -4096);
		send_event(MODE_MOVE, 4095, 4095);
		send_event(MODE_MOVE, -4096, 4095);
		// release stops, drag without capture sends nothing, leave stops
		send_event(MODE_RELEASE, 0, 0);
		send_event(MODE_MOVE, 320, 0);
		send_event(MODE_LEAVE, 0, 0);
		send_event(MODE_LEAVE, 0, 0);
		send_event(MODE_RELEASE, 0, 0);

		// dead zone: press inside, leave it, come back, stay
		drain();
		write_reg(REG_DEAD_ZONE, 50);
		cfg_valid <= 1'b0;
		cur_rad = 50;
		send_event(MODE_PRESS, 330, 240);
		send_event(MODE_MOVE, 400, 240);
		send_event(MODE_MOVE, 320, 250);
		send_event(MODE_MOVE, 320, 250);
		send_event(MODE_MOVE, 320, 100);
		send_event(MODE_LEAVE, 0, 0);

		// control switched off while hovering, release still stops
		send_event(MODE_PRESS, 320, 0);
		drain();
		write_reg(REG_VIDEO_ACTIVE, 0);
		cfg_valid <= 1'b0;
		send_event(MODE_RELEASE, 0, 0);
		send_event(MODE_MOVE, 320, 0);

		// random phases over several settings
		apply_setting(640, 480, 0, 32, 1'b1);
		run_phase(150);
		apply_setting(1, 1, 2048, 255, 1'b1);
		run_phase(140);
		calm <= 1'b1;
		apply_setting(4096, 4096, 0, 0, 1'b1);
		run_phase(150);
		calm <= 1'b0;
		apply_setting(8191, 8191, 8191, 8191, 1'b1);
		run_phase(140);
		apply_setting(0, 0, 0, 8'h55, 1'b1);
		run_phase(120);
		apply_setting($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(0, 300), $urandom_range(0, 255), 1'b1);
		run_phase(150);
		apply_setting(640, 480, 100, 200, 1'b0);
		run_phase(40);
		apply_setting($urandom_range(1, 4096), $urandom_range(1, 4096),
			$urandom_range(0, 300), $urandom_range(0, 255), 1'b1);
		run_phase(150);

		// wind down
		drain();
		repeat (8) @(negedge clk);
		$display("covered %0d pointer events, %0d result beats, %0d register writes",
			events_seen, beats_seen, writes_seen);
		$display("over %0d view settings incl. tiny, huge, oversized and inactive; %0d errors",
			settings_run, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("[drag_to_ptz_direction_commander_unit] OK");
		else
			$display("[drag_to_ptz_direction_commander_unit] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/d2ptz_pkg.sv
src/drag_to_ptz_direction_commander_unit.sv
sim/d2ptz_checker.sv
sim/drag_to_ptz_direction_commander_unit_tb.sv
